/* hdl/mstw_pkg.sv */
// ---------------------------------------------------------------------------
// Multi-slot tick timer package
// Shared widths, operation and status codes, and reset values of the timer.
// ---------------------------------------------------------------------------
package mstw_pkg;

	localparam int SLOTS_DEFAULT = 8;

	localparam int OPCODE_W   = 3;
	localparam int SLOT_W     = 8;
	localparam int INTERVAL_W = 32;
	localparam int STATUS_W   = 2;
	localparam int SLOT_ID_W  = 3;
	localparam int MASK_W     = 8;
	localparam int TICKS_W    = 32;
	localparam int WD_W       = 17;
	localparam int LIMIT_W    = 16;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WD_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WD_LIMIT  = 1'd1;

	localparam logic [LIMIT_W-1:0] WD_LIMIT_RESET = 16'd1000;
	localparam logic [WD_W-1:0]    WD_MAX         = 17'h1FFFF;

	localparam logic [OPCODE_W-1:0] OP_TICK         = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_REGISTER     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_UNREGISTER   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SET_INTERVAL = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_KICK         = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_HALTED   = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_ID_W-1:0]  slot_id;
		logic [MASK_W-1:0]     expired_mask;
		logic                  watchdog_fired;
		logic [TICKS_W-1:0]    tick_count;
	} result_t;

endpackage

/* hdl/multi_slot_tick_timer_watchdog_core.sv */
// ---------------------------------------------------------------------------
// Multi-slot tick timer with watchdog
// Eight (SLOTS) software-style timer slots, a free-running tick count and a
// sticky watchdog, driven by one operation per input transaction.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      opcode, slot, interval
// m_axis    out        m_axis_tvalid/tready      status, slot_id, expired_mask,
//                                                watchdog_fired, tick_count
// cfg       in         cfg_we (no back-pressure) watchdog_enable, watchdog_limit
//
// A tick that does not fire the watchdog visits the slots one per cycle
// through a single increment-and-compare unit, so its result is registered
// once the sweep and the drain state are done. Every other operation, and a
// firing tick, answers in the cycle after acceptance. The slot counters and
// intervals live in small memories with a registered read port; the active
// marks are flip-flops cleared by reset, so no clearing pass is needed.
// The block takes a new transaction only when idle and its output register is
// empty or being emptied in the same cycle; a stalled output holds the block.
// Reset is asynchronous and active low.

module multi_slot_tick_timer_watchdog_core
	import mstw_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] opcode, [10:3] slot, [42:11] interval, [47:43] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [4:2] slot_id, [12:5] expired_mask, [13] watchdog_fired,
	// [45:14] tick_count, [47:46] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,

	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_TICK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	// Input fields.
	logic [OPCODE_W-1:0]   in_opcode;
	logic [SLOT_W-1:0]     in_slot;
	logic [INTERVAL_W-1:0] in_interval;

	assign in_opcode   = s_axis_tdata[OPCODE_W-1:0];
	assign in_slot     = s_axis_tdata[OPCODE_W +: SLOT_W];
	assign in_interval = s_axis_tdata[OPCODE_W+SLOT_W +: INTERVAL_W];

	// Configuration and control state.
	logic                 wd_enable_q;
	logic [LIMIT_W-1:0]   wd_limit_q;
	logic [WD_W-1:0]      wd_count_q;
	logic                 halted_q;
	logic [TICKS_W-1:0]   ticks_q;
	logic [SLOTS-1:0]     active_q;
	logic [1:0]           state_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [MASK_W-1:0]    mask_q;
	logic                 m_valid_q;
	result_t              result_q;

	// Slot memories: written at one address, read at one address, read data
	// registered into the first stage of the tick datapath.
	logic [INTERVAL_W-1:0] ivl_mem [SLOTS];
	logic [INTERVAL_W-1:0] cnt_mem [SLOTS];

	// Tick datapath stage one.
	logic                  vld_s1;
	logic                  last_s1;
	logic                  act_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [INTERVAL_W-1:0] ivl_s1;
	logic [INTERVAL_W-1:0] cnt_s1;

	// Handshake.
	logic accept;
	logic out_free;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}},
		result_q.tick_count, result_q.watchdog_fired, result_q.expired_mask,
		result_q.slot_id, result_q.status};

	// Slot number checks for unregister and set interval.
	logic             slot_ok;
	logic [IDX_W-1:0] slot_idx;

	assign slot_ok  = (32'(in_slot) < SLOTS);
	assign slot_idx = IDX_W'(in_slot);

	// Lowest free slot for register.
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!active_q[k]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
		end
	end

	// Watchdog update on a tick.
	logic [WD_W-1:0] wd_next;
	logic            wd_fire;

	assign wd_next = (wd_count_q < WD_MAX) ? wd_count_q + 1'b1 : wd_count_q;
	assign wd_fire = wd_next > WD_W'(wd_limit_q);

	// The shared increment-and-compare unit: one slot per cycle.
	logic [INTERVAL_W-1:0] cnt_inc;
	logic                  hit;
	logic [MASK_W-1:0]     mask_set;
	logic [MASK_W-1:0]     mask_next;

	assign cnt_inc = cnt_s1 + 1'b1;
	assign hit     = cnt_inc >= ivl_s1;

	always_comb begin
		mask_set = '0;
		for (int b = 0; b < MASK_W; b++) begin
			mask_set[b] = vld_s1 && act_s1 && hit && (32'(idx_s1) == b);
		end
	end

	assign mask_next = mask_q | mask_set;

	// Memory write ports.
	logic                  ivl_we;
	logic [IDX_W-1:0]      ivl_waddr;
	logic                  cnt_we;
	logic [IDX_W-1:0]      cnt_waddr;
	logic [INTERVAL_W-1:0] cnt_wdata;
	logic                  do_op;

	assign do_op = accept && !halted_q;

	always_comb begin
		ivl_we    = 1'b0;
		ivl_waddr = free_idx;
		cnt_we    = 1'b0;
		cnt_waddr = free_idx;
		cnt_wdata = '0;
		if (vld_s1 && act_s1) begin
			cnt_we    = 1'b1;
			cnt_waddr = idx_s1;
			cnt_wdata = hit ? '0 : cnt_inc;
		end else if (do_op && in_opcode == OP_REGISTER && free_found) begin
			ivl_we = 1'b1;
			cnt_we = 1'b1;
		end else if (do_op && in_opcode == OP_SET_INTERVAL && slot_ok
				&& in_interval != '0) begin
			ivl_we    = 1'b1;
			ivl_waddr = slot_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ivl_we) begin
			ivl_mem[ivl_waddr] <= in_interval;
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		ivl_s1  <= ivl_mem[rd_idx_q];
		cnt_s1  <= cnt_mem[rd_idx_q];
		act_s1  <= active_q[rd_idx_q];
		idx_s1  <= rd_idx_q;
		last_s1 <= (rd_idx_q == LAST_IDX);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_enable_q <= 1'b0;
			wd_limit_q  <= WD_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WD_ENABLE: wd_enable_q <= cfg_data[0];
				CFG_WD_LIMIT:  wd_limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			mask_q     <= '0;
			wd_count_q <= '0;
			halted_q   <= 1'b0;
			ticks_q    <= '0;
			active_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						m_valid_q <= 1'b1;
						if (!halted_q) begin
							case (in_opcode)
								OP_TICK: begin
									if (wd_enable_q) begin
										wd_count_q <= wd_next;
									end
									if (wd_enable_q && wd_fire) begin
										halted_q <= 1'b1;
									end else begin
										// The result waits for the slot sweep.
										m_valid_q <= 1'b0;
										ticks_q   <= ticks_q + 1'b1;
										mask_q    <= '0;
										rd_idx_q  <= '0;
										state_q   <= S_TICK;
									end
								end
								OP_REGISTER: begin
									if (free_found) begin
										active_q[free_idx] <= 1'b1;
									end
								end
								OP_UNREGISTER: begin
									if (slot_ok) begin
										active_q[slot_idx] <= 1'b0;
									end
								end
								OP_SET_INTERVAL: begin
									if (slot_ok && in_interval == '0) begin
										active_q[slot_idx] <= 1'b0;
									end
								end
								OP_KICK: begin
									wd_count_q <= '0;
								end
								default: ;
							endcase
						end
					end
				end
				S_TICK: begin
					vld_s1   <= 1'b1;
					mask_q   <= mask_next;
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					vld_s1 <= 1'b0;
					mask_q <= mask_next;
					if (vld_s1 && last_s1) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	// Result register; only loaded while the output is free.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.status         <= ST_OK;
			result_q.slot_id        <= '0;
			result_q.expired_mask   <= '0;
			result_q.watchdog_fired <= 1'b0;
			result_q.tick_count     <= ticks_q;
			if (halted_q) begin
				result_q.status <= ST_HALTED;
			end else begin
				case (in_opcode)
					OP_TICK: begin
						if (wd_enable_q && wd_fire) begin
							result_q.status         <= ST_HALTED;
							result_q.watchdog_fired <= 1'b1;
						end
					end
					OP_REGISTER: begin
						if (free_found) begin
							result_q.slot_id <= SLOT_ID_W'(free_idx);
						end else begin
							result_q.status <= ST_FULL;
						end
					end
					OP_UNREGISTER, OP_SET_INTERVAL: begin
						if (!slot_ok) begin
							result_q.status <= ST_BAD_SLOT;
						end
					end
					default: ;
				endcase
			end
		end else if (state_q == S_DRAIN && vld_s1 && last_s1) begin
			result_q.expired_mask <= mask_next;
			result_q.tick_count   <= ticks_q;
		end
	end

endmodule

/* bench/mstw_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer bench scoreboard
// Keeps a copy of the slot, tick and watchdog state, works out the expected
// response to each accepted operation and checks the block's responses in
// order against it.
// ---------------------------------------------------------------------------
package mstw_tb_pkg;
	import mstw_pkg::*;

	class timer_scoreboard;
		localparam int N = SLOTS_DEFAULT;

		bit                    wd_enable;
		logic [LIMIT_W-1:0]    wd_limit;
		bit                    active [N];
		logic [INTERVAL_W-1:0] period [N];
		logic [INTERVAL_W-1:0] count [N];
		logic [TICKS_W-1:0]    ticks;
		logic [WD_W-1:0]       wd_count;
		bit                    halted;

		result_t expected_responses [$];

		int errors;
		int responses_seen;
		int ops_seen;
		int ticks_sent;
		int expiring_ticks;
		int full_answers;
		int bad_slot_answers;
		int halted_answers;

		function new();
			wd_enable = 1'b0;
			wd_limit  = WD_LIMIT_RESET;
			for (int k = 0; k < N; k++) begin
				active[k] = 1'b0;
				period[k] = '0;
				count[k]  = '0;
			end
			ticks    = '0;
			wd_count = '0;
			halted   = 1'b0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_WD_ENABLE)
				wd_enable = data[0];
			else if (idx == CFG_WD_LIMIT)
				wd_limit = data[LIMIT_W-1:0];
		endfunction

		function int pending();
			return expected_responses.size();
		endfunction

		// True when the next tick would trip the watchdog.
		function bit tick_would_fire();
			logic [WD_W-1:0] nxt;
			nxt = (wd_count == WD_MAX) ? WD_MAX : wd_count + 1'b1;
			return !halted && wd_enable && (nxt > {1'b0, wd_limit});
		endfunction

		function void note_operation(input logic [OPCODE_W-1:0] op,
				input logic [SLOT_W-1:0] sl, input logic [INTERVAL_W-1:0] iv);
			result_t r;
			bit      placed;
			r = '0;
			placed = 1'b0;
			ops_seen++;
			if (halted) begin
				r.status = ST_HALTED;
			end else begin
				case (op)
				OP_TICK: begin
					ticks_sent++;
					if (wd_enable) begin
						if (wd_count != WD_MAX)
							wd_count = wd_count + 1'b1;
						if (wd_count > {1'b0, wd_limit}) begin
							halted = 1'b1;
							r.watchdog_fired = 1'b1;
							r.status = ST_HALTED;
						end
					end
					if (!halted) begin
						ticks = ticks + 1'b1;
						for (int k = 0; k < N; k++) begin
							if (active[k]) begin
								count[k] = count[k] + 1'b1;
								if (count[k] >= period[k]) begin
									count[k] = '0;
									r.expired_mask[k] = 1'b1;
								end
							end
						end
						if (r.expired_mask != '0)
							expiring_ticks++;
					end
				end
				OP_REGISTER: begin
					r.status = ST_FULL;
					for (int k = 0; k < N; k++) begin
						if (!placed && !active[k]) begin
							placed    = 1'b1;
							active[k] = 1'b1;
							period[k] = iv;
							count[k]  = '0;
							r.slot_id = k[SLOT_ID_W-1:0];
							r.status  = ST_OK;
						end
					end
				end
				OP_UNREGISTER: begin
					if (sl >= N)
						r.status = ST_BAD_SLOT;
					else
						active[sl] = 1'b0;
				end
				OP_SET_INTERVAL: begin
					if (sl >= N)
						r.status = ST_BAD_SLOT;
					else if (iv == '0)
						active[sl] = 1'b0;
					else
						period[sl] = iv;
				end
				OP_KICK: begin
					wd_count = '0;
				end
				default: begin
				end
				endcase
			end
			r.tick_count = ticks;
			case (r.status)
			ST_FULL:     full_answers++;
			ST_BAD_SLOT: bad_slot_answers++;
			ST_HALTED:   halted_answers++;
			default:     ;
			endcase
			expected_responses.push_back(r);
		endfunction

		function void report(input string what, input longint unsigned want,
				input longint unsigned got);
			errors++;
			if (errors <= 40)
				$display("MISMATCH response %0d %s: expected 0x%0h, got 0x%0h",
					responses_seen, what, want, got);
		endfunction

		function void check_response(input logic [OUT_TDATA_W-1:0] td);
			result_t want;
			responses_seen++;
			if (expected_responses.size() == 0) begin
				report("unexpected response", 0, td);
				return;
			end
			want = expected_responses.pop_front();
			if (td[1:0] !== want.status)
				report("status", want.status, td[1:0]);
			if (td[4:2] !== want.slot_id)
				report("slot_id", want.slot_id, td[4:2]);
			if (td[12:5] !== want.expired_mask)
				report("expired_mask", want.expired_mask, td[12:5]);
			if (td[13] !== want.watchdog_fired)
				report("watchdog_fired", want.watchdog_fired, td[13]);
			if (td[45:14] !== want.tick_count)
				report("tick_count", want.tick_count, td[45:14]);
			if (td[47:46] !== 2'b00)
				report("padding", 0, td[47:46]);
		endfunction
	endclass

endpackage

/* bench/tb_multi_slot_tick_timer_watchdog_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-slot tick timer bench
// Drives operations into the timer through its input stream, predicts every
// response with a scoreboard and checks the output stream against it, across
// several watchdog settings, with random gaps and back-pressure.
// ---------------------------------------------------------------------------
module tb_multi_slot_tick_timer_watchdog_core;
	import mstw_pkg::*;
	import mstw_tb_pkg::*;

	// Far beyond the slowest legal run: about 1400 operations, each at most a
	// full slot sweep in the block, plus long sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 2 * SLOTS_DEFAULT + 4;
	localparam int PAD_W       = IN_TDATA_W - OPCODE_W - SLOT_W - INTERVAL_W;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [2:0] opcode, [10:3] slot, [42:11] interval, [47:43] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [1:0] status, [4:2] slot_id, [12:5] expired_mask, [13] watchdog_fired,
	// [45:14] tick_count, [47:46] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Percentages of cycles in which the sender holds back or the receiver
	// refuses a transaction; changed from phase to phase.
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	timer_scoreboard sb;

	multi_slot_tick_timer_watchdog_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// The run is bounded by a plain cycle count; running past it means the
	// block has hung or lost a transaction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("tb_multi_slot_tick_timer_watchdog_core NOT OK");
			$finish;
		end
	end

	// Output side: a transaction completes at an edge where tvalid and tready
	// were both high before the edge, so the values seen here are the ones
	// that were on the bus. Ready is redrawn every cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_response(m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Offers one operation, with a random gap in front of it, and returns at
	// the edge that accepted it. Callers are always just past a rising edge.
	task automatic send_operation(input logic [OPCODE_W-1:0] op,
			input logic [SLOT_W-1:0] sl, input logic [INTERVAL_W-1:0] iv);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{PAD_W{1'b0}}, iv, sl, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_operation(op, sl, iv);
	endtask

	// Registers may only change with the block idle: the input is withdrawn,
	// every response must have come back, and a few spare cycles follow.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input bit enable, input logic [LIMIT_W-1:0] limit);
		drain();
		write_reg(CFG_WD_ENABLE, {{(CFG_DATA_W-1){1'b0}}, enable});
		write_reg(CFG_WD_LIMIT, limit);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random operation. Most traffic is ticks and slot management on valid
	// slots with short intervals, so slots fill, expire and free up often;
	// the rest is bad slot numbers, huge intervals and unused opcodes. With
	// keep_alive set, a tick that would trip the watchdog becomes a kick, so
	// the counter is driven right up to its limit without halting the block.
	task automatic random_operation(input bit keep_alive);
		int                    pick;
		logic [OPCODE_W-1:0]   op;
		logic [SLOT_W-1:0]     sl;
		logic [INTERVAL_W-1:0] iv;
		pick = $urandom_range(0, 99);
		if (pick < 42)
			op = OP_TICK;
		else if (pick < 58)
			op = OP_REGISTER;
		else if (pick < 70)
			op = OP_UNREGISTER;
		else if (pick < 82)
			op = OP_SET_INTERVAL;
		else if (pick < 93)
			op = OP_KICK;
		else
			op = OPCODE_W'($urandom_range(OP_KICK + 1, 7));
		if ($urandom_range(0, 99) < 88)
			sl = SLOT_W'($urandom_range(0, SLOTS_DEFAULT - 1));
		else
			sl = SLOT_W'($urandom_range(SLOTS_DEFAULT, 255));
		pick = $urandom_range(0, 99);
		if (pick < 50)
			iv = $urandom_range(0, 6);
		else if (pick < 72)
			iv = $urandom_range(0, 40);
		else if (pick < 92)
			iv = $urandom;
		else
			iv = '1;
		if (keep_alive && op == OP_TICK && sb.tick_would_fire())
			op = OP_KICK;
		send_operation(op, sl, iv);
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with reset settings (watchdog off, limit 1000).
		sender_idle_pct = 30;
		recv_stall_pct  = 70;
		send_operation(OP_TICK, 8'hFF, 32'hFFFF_FFFF);   // tick with no slots in use
		send_operation(OP_REGISTER, 8'h00, 32'd0);       // slot 0, expires every tick
		send_operation(OP_REGISTER, 8'hFF, 32'd1);       // slot 1
		send_operation(OP_REGISTER, 8'h00, 32'd3);       // slot 2
		send_operation(OP_REGISTER, 8'h00, 32'hFFFF_FFFF); // slot 3, never expires
		send_operation(OP_TICK, 8'h00, 32'd0);
		send_operation(OP_TICK, 8'h00, 32'd0);
		// Slot 2 has counted two ticks; a shorter interval makes it expire next.
		send_operation(OP_SET_INTERVAL, 8'd2, 32'd1);
		send_operation(OP_TICK, 8'h00, 32'd0);
		send_operation(OP_SET_INTERVAL, 8'd0, 32'd0);    // interval zero frees slot 0
		send_operation(OP_SET_INTERVAL, 8'd6, 32'd5);    // inactive slot stays inactive
		send_operation(OP_UNREGISTER, 8'd7, 32'd0);      // already free
		send_operation(OP_UNREGISTER, 8'd8, 32'd0);      // first bad slot number
		send_operation(OP_SET_INTERVAL, 8'hFF, 32'd9);   // last bad slot number
		send_operation(3'd5, 8'd0, 32'd0);
		send_operation(3'd6, 8'd0, 32'd0);
		send_operation(3'd7, 8'd0, 32'd0);
		send_operation(OP_KICK, 8'd0, 32'd0);
		send_operation(OP_REGISTER, 8'd0, 32'd2);        // lowest free slot is 0 again
		for (int i = 0; i < 5; i++)                      // slots 4 to 7, then full
			send_operation(OP_REGISTER, 8'd0, 32'd4);
		send_operation(OP_TICK, 8'd0, 32'd0);
		send_operation(OP_UNREGISTER, 8'd3, 32'd0);

		// Watchdog counting towards the largest limit, kicked as needed.
		configure(1'b1, 16'hFFFF);
		for (int i = 0; i < 450; i++)
			random_operation(1'b1);

		// A small limit keeps the watchdog close to firing all the time.
		sender_idle_pct = 70;
		recv_stall_pct  = 30;
		configure(1'b1, LIMIT_W'($urandom_range(3, 12)));
		for (int i = 0; i < 450; i++)
			random_operation(1'b1);

		// Watchdog off, back-to-back traffic.
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		configure(1'b0, WD_LIMIT_RESET);
		for (int i = 0; i < 450; i++)
			random_operation(1'b0);

		// Limit zero: the first tick after a kick fires the watchdog, and
		// everything after it, kicks included, must answer as halted.
		configure(1'b1, 16'd0);
		send_operation(OP_KICK, 8'd0, 32'd0);
		send_operation(OP_TICK, 8'd0, 32'd0);
		send_operation(OP_KICK, 8'd0, 32'd0);
		for (int i = 0; i < 20; i++)
			random_operation(1'b0);

		drain();
		if (sb.pending() != 0)
			sb.report("responses still missing", 0, sb.pending());
		$display("Ran %0d operations (%0d ticks, %0d with expiries), %0d responses checked.",
			sb.ops_seen, sb.ticks_sent, sb.expiring_ticks, sb.responses_seen);
		$display("Answers: %0d full, %0d bad slot, %0d halted; %0d mismatches.",
			sb.full_answers, sb.bad_slot_answers, sb.halted_answers, sb.errors);
		if (sb.errors == 0)
			$display("tb_multi_slot_tick_timer_watchdog_core OK");
		else
			$display("tb_multi_slot_tick_timer_watchdog_core NOT OK");
		$finish;
	end

endmodule

/* multi_slot_tick_timer_watchdog_core.f */
hdl/mstw_pkg.sv
hdl/multi_slot_tick_timer_watchdog_core.sv
bench/mstw_tb_pkg.sv
bench/tb_multi_slot_tick_timer_watchdog_core.sv
